### src/vpa_pkg.sv
// Shared constants, codes and types of the partition allocator.
`timescale 1ns / 1ps
`default_nettype none
package vpa_pkg;
  localparam int MAX_ENTRIES = 64;
  localparam int SIZE_BITS   = 20;
  localparam int OWNER_BITS  = 8;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_APPEND  = 2'd1;
  localparam logic [1:0] KIND_ALLOC   = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NONE  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_NOOWNER = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  size;
    logic                  free;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

### src/variable_partition_allocator.sv
// Top level: partition table sequencer around one entry RAM.
// Clear and append complete on acceptance; allocate scans the table and, for a split,
// shifts the blocks above the chosen index up; release finds the owner, then frees and merges.
// Throughput: one request at a time; a new request is accepted only in the idle state.
// Reset clears the block count, total size and control; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module variable_partition_allocator
  import vpa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           kind_i,
  input  wire logic [1:0]           strategy_i,
  input  wire logic [7:0]           owner_id_i,
  input  wire logic [SIZE_BITS-1:0] amount_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [2:0]                status_o,
  output logic [IDX_W-1:0]          chosen_index_o,
  output logic [CNT_W-1:0]          entries_used_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FIXK  = 3'd3;
  localparam logic [2:0] S_FIXK1 = 3'd4;
  localparam logic [2:0] S_FIND  = 3'd5;
  localparam logic [2:0] S_MERGE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      ra_q, ra_d, used_q, used_d, wr_q, wr_d;
  logic                  rv_q, rv_d, found_q, found_d, pend_v_q, pend_v_d;
  logic [IDX_W-1:0]      rix_q, rix_d, pk_q, pk_d, ch_q, ch_d;
  logic [SIZE_BITS-1:0]  total_q, total_d, amt_q, amt_d, pksz_q, pksz_d;
  logic [1:0]            rule_q, rule_d;
  logic [OWNER_BITS-1:0] own_q, own_d;
  logic [2:0]            st_q, st_d;
  entry_t                pend_q, pend_d;
  logic                  ov_q, ov_d;
  logic [2:0]            ost_q, ost_d;
  logic [IDX_W-1:0]      och_q, och_d;
  logic [CNT_W-1:0]      oused_q, oused_d;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  entry_t                wdata, rdata;
  logic [ENTRY_W-1:0]    rdata_raw;

  vpa_ram #(.Width(ENTRY_W), .Depth(MAX_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ra_q[IDX_W-1:0]),
    .rdata_o (rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  always_comb begin
    logic                 iss;
    logic                 cand;
    logic [SIZE_BITS:0]   sum;
    logic [SIZE_BITS-1:0] rest;
    entry_t               e;
    state_d = state_q; ra_d = ra_q; used_d = used_q; wr_d = wr_q;
    rv_d = 1'b0; found_d = found_q; pend_v_d = pend_v_q; rix_d = ra_q[IDX_W-1:0];
    pk_d = pk_q; ch_d = ch_q; total_d = total_q; amt_d = amt_q; pksz_d = pksz_q;
    rule_d = rule_q; own_d = own_q; st_d = st_q; pend_d = pend_q;
    ov_d = ov_q & out_stall_i; ost_d = ost_q; och_d = och_q; oused_d = oused_q;
    we = 1'b0; waddr = '0; wdata = '0;
    iss = 1'b0;
    sum = {1'b0, total_q} + {1'b0, amount_i};
    rest = pksz_q - amt_q;
    e = rdata;
    cand = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rule_d = strategy_i; own_d = owner_id_i[OWNER_BITS-1:0]; amt_d = amount_i;
          st_d = ST_OK; ch_d = '0; ra_d = '0; found_d = 1'b0;
          state_d = S_DONE;
          unique case (kind_i)
            KIND_CLEAR: begin
              used_d = '0; total_d = '0;
            end
            KIND_APPEND: begin
              if (amount_i == '0) begin
                st_d = ST_ZERO;
              end else if (used_q == CNT_W'(MAX_ENTRIES) || sum[SIZE_BITS]) begin
                st_d = ST_FULL;
              end else begin
                we = 1'b1; waddr = used_q[IDX_W-1:0];
                wdata = '{size: amount_i, free: 1'b1, owner: '0};
                ch_d = used_q[IDX_W-1:0]; used_d = used_q + 1'b1;
                total_d = sum[SIZE_BITS-1:0];
              end
            end
            KIND_ALLOC: begin
              if (amount_i == '0) st_d = ST_ZERO;
              else if (strategy_i == FIT_NONE) st_d = ST_NOFIT;
              else state_d = S_SCAN;
            end
            default: state_d = S_FIND;
          endcase
        end
      end
      S_SCAN: begin
        iss = ra_q < used_q;
        if (iss) ra_d = ra_q + 1'b1;
        rv_d = iss;
        if (rv_q) begin
          cand = e.free && (e.size >= amt_q);
          if (cand && (!found_q || (rule_q == FIT_BEST && e.size < pksz_q) ||
                       (rule_q == FIT_WORST && e.size > pksz_q))) begin
            found_d = 1'b1; pk_d = rix_q; pksz_d = e.size;
          end
        end else if (!iss) begin
          if (!found_q) begin
            st_d = ST_NOFIT; state_d = S_DONE;
          end else if (rest != '0 && used_q != CNT_W'(MAX_ENTRIES)) begin
            ra_d = used_q - 1'b1; state_d = S_SHIFT;
          end else begin
            we = 1'b1; waddr = pk_q;
            wdata = '{size: pksz_q, free: 1'b0, owner: own_q};
            ch_d = pk_q; state_d = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        iss = ra_q > {1'b0, pk_q};
        if (iss) ra_d = ra_q - 1'b1;
        rv_d = iss;
        if (rv_q) begin
          we = 1'b1; waddr = rix_q + 1'b1; wdata = e;
        end else if (!iss) begin
          state_d = S_FIXK;
        end
      end
      S_FIXK: begin
        we = 1'b1; waddr = pk_q;
        wdata = '{size: amt_q, free: 1'b0, owner: own_q};
        state_d = S_FIXK1;
      end
      S_FIXK1: begin
        we = 1'b1; waddr = pk_q + 1'b1;
        wdata = '{size: rest, free: 1'b1, owner: '0};
        used_d = used_q + 1'b1; ch_d = pk_q; state_d = S_DONE;
      end
      S_FIND: begin
        iss = ra_q < used_q;
        if (iss) ra_d = ra_q + 1'b1;
        rv_d = iss;
        if (rv_q) begin
          if (!e.free && e.owner == own_q) found_d = 1'b1;
        end else if (!iss) begin
          if (found_q) begin
            ra_d = '0; wr_d = '0; pend_v_d = 1'b0; state_d = S_MERGE;
          end else begin
            st_d = ST_NOOWNER; state_d = S_DONE;
          end
        end
      end
      S_MERGE: begin
        iss = ra_q < used_q;
        if (iss) ra_d = ra_q + 1'b1;
        rv_d = iss;
        if (rv_q) begin
          if (!e.free && e.owner == own_q) begin
            e.free = 1'b1; e.owner = '0;
          end
          if (pend_v_q && pend_q.free && e.free) begin
            pend_d.size = pend_q.size + e.size;
          end else begin
            if (pend_v_q) begin
              we = 1'b1; waddr = wr_q[IDX_W-1:0]; wdata = pend_q;
              wr_d = wr_q + 1'b1;
            end
            pend_d = e; pend_v_d = 1'b1;
          end
        end else if (!iss) begin
          we = 1'b1; waddr = wr_q[IDX_W-1:0]; wdata = pend_q;
          used_d = wr_q + 1'b1; state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1; ost_d = st_q; och_d = ch_q; oused_d = used_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; total_q <= '0; rv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; total_q <= total_d; rv_q <= rv_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= ra_d; wr_q <= wr_d; found_q <= found_d; pend_v_q <= pend_v_d;
    rix_q <= rix_d; pk_q <= pk_d; ch_q <= ch_d; amt_q <= amt_d; pksz_q <= pksz_d;
    rule_q <= rule_d; own_q <= own_d; st_q <= st_d; pend_q <= pend_d;
    ost_q <= ost_d; och_q <= och_d; oused_q <= oused_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ov_q;
  assign status_o       = ost_q;
  assign chosen_index_o = och_q;
  assign entries_used_o = oused_q;
endmodule
`default_nettype wire

### src/vpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module vpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### src/vpa_checker.sv
// Port-level checks of the partition allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vpa_checker
  import vpa_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [2:0]           status_o,
  input wire logic [IDX_W-1:0]     chosen_index_o,
  input wire logic [CNT_W-1:0]     entries_used_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(chosen_index_o) && $stable(entries_used_o))
    else $error("stalled result changed");
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> chosen_index_o == '0)
    else $error("index on failed request");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entries_used_o <= CNT_W'(MAX_ENTRIES))
    else $error("block count overflow");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_ZERO)
    else $error("bad status");
endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (.*);
`default_nettype wire
